// File: rtl/lle_pkg.sv
// Shared codes, widths, defaults and helper functions of the login line editor.
package lle_pkg;

    // Field widths fixed by the stream format
    localparam int CHAR_W      = 7;
    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int LINE_LEN_W  = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int OUT_DATA_W  = 24;

    // Parameter defaults
    localparam int LINE_CAPACITY_DEF = 16;
    localparam int BLANK_RUN_DEF     = 37;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ERASE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KILL   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EOF    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IGNORE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOW   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_PARITY = 3'd5;

    // Configuration reset values
    localparam logic [CHAR_W-1:0] ERASE_RST = 7'd127;
    localparam logic [CHAR_W-1:0] KILL_RST  = 7'd21;
    localparam logic [CHAR_W-1:0] EOF_RST   = 7'd4;

    // Echo parity modes; the unused code behaves as even
    localparam logic [1:0] PAR_NONE = 2'd0;
    localparam logic [1:0] PAR_EVEN = 2'd1;
    localparam logic [1:0] PAR_ODD  = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ECHO   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_EDIT     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DONE     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NUL      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EOF      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_REPROMPT = 3'd4;

    // Characters
    localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] CH_BS    = 7'h08;
    localparam logic [CHAR_W-1:0] CH_LF    = 7'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 7'h0D;
    localparam logic [CHAR_W-1:0] CH_SP    = 7'h20;
    localparam logic [CHAR_W-1:0] CH_HASH  = 7'h23;
    localparam logic [CHAR_W-1:0] CH_D0    = 7'h30;
    localparam logic [CHAR_W-1:0] CH_D9    = 7'h39;
    localparam logic [CHAR_W-1:0] CH_AT    = 7'h40;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 7'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 7'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 7'h7A;
    localparam logic [CHAR_W-1:0] CH_TILDE = 7'h7E;

    // What an accepted beat turned into
    typedef enum logic [2:0] {
        CLS_QUIET = 3'd0,   // status only, editing
        CLS_NUL   = 3'd1,
        CLS_EOF   = 3'd2,
        CLS_DONE  = 3'd3,
        CLS_ERASE = 3'd4,
        CLS_KILL  = 3'd5,
        CLS_STORE = 3'd6
    } cls_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // take the input beat this cycle
        logic emit;     // load the current result into the output register
        logic final_;   // current result is the last of this input
    } dp_cmd_t;

    function automatic logic [BYTE_W-1:0] echo_parity(logic [BYTE_W-1:0] b,
                                                      logic [1:0] mode);
        logic [BYTE_W-1:0] r;
        r = b;
        if (mode != PAR_NONE) begin
            if (^b[CHAR_W-1:0]) begin
                r[BYTE_W-1] = 1'b1;
            end
            if (mode == PAR_ODD) begin
                r[BYTE_W-1] = ~r[BYTE_W-1];
            end
        end
        return r;
    endfunction

    function automatic logic [STATUS_W-1:0] status_of(cls_t c);
        logic [STATUS_W-1:0] s;
        unique case (c)
            CLS_NUL:  s = STAT_NUL;
            CLS_EOF:  s = STAT_EOF;
            CLS_DONE: s = STAT_DONE;
            CLS_KILL: s = STAT_REPROMPT;
            default:  s = STAT_EDIT;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/lle_ram.sv
// Generic single write port, single read port RAM with registered read.
module lle_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/lle_ctrl.sv
// Sequencing controller: accepts a beat, then steps through its results.
module lle_ctrl import lle_pkg::*; #(
    parameter int SEQ_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             out_free,
    input  logic [SEQ_W-1:0] seq_len,
    output dp_cmd_t          cmd,
    output logic [SEQ_W-1:0] step
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [SEQ_W-1:0] step_reg, step_next;
    logic             is_final;

    assign is_final = (step_reg == seq_len - SEQ_W'(1));

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.final_ = is_final;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    cmd.emit = 1'b1;
                    if (is_final) begin
                        state_next = ST_IDLE;
                    end else begin
                        step_next = step_reg + SEQ_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign step     = step_reg;

endmodule

// File: rtl/lle_datapath.sv
// Datapath: config registers, line store, edit decode and result register.
module lle_datapath import lle_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
    parameter int BLANK_RUN     = BLANK_RUN_DEF,
    parameter int SEQ_W         = 6
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_op,
    input  logic [BYTE_W-1:0]      in_byte,
    input  dp_cmd_t                cmd,
    input  logic [SEQ_W-1:0]       step,
    output logic [SEQ_W-1:0]       seq_len,
    output logic                   out_free,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic [KIND_W-1:0]      m_tuser,
    output logic                   m_tlast
);

    localparam int FILL_W = $clog2(LINE_CAPACITY + 1);
    localparam int ADDR_W = $clog2(LINE_CAPACITY);

    // configuration
    logic [CHAR_W-1:0] erase_reg, kill_reg, eof_reg;
    logic              ignore_reg, slow_reg;
    logic [1:0]        parity_reg;

    // line state
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              lower_reg, lower_next;
    logic              upper_reg, upper_next;
    logic              digit_reg, digit_next;

    // per-beat context
    cls_t              cls_reg, cls_next;
    logic [BYTE_W-1:0] raw_reg;
    logic              cr_reg, cr_next;
    logic [SEQ_W-1:0]  seq_len_reg, seq_len_next;

    // output register
    logic                  m_valid_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic [BYTE_W-1:0]     byte_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [LINE_LEN_W-1:0] len_reg;
    logic                  olower_reg, oupper_reg, odigit_reg, ocr_reg, last_reg;

    logic [CHAR_W-1:0] c;
    logic              is_lower, is_upper, is_digit, is_erase, is_kill, is_ctrl;
    logic              dec_store;
    logic              clear_at_end;

    logic              ram_we, ram_re;
    logic [SEQ_W-1:0]  rd_idx;
    logic [CHAR_W-1:0] ram_rdata;

    logic [KIND_W-1:0] item_kind;
    logic [BYTE_W-1:0] item_char;
    logic [BYTE_W-1:0] item_byte;

    assign c        = in_byte[CHAR_W-1:0];
    assign is_lower = (c >= CH_LO_A) && (c <= CH_LO_Z);
    assign is_upper = (c >= CH_UP_A) && (c <= CH_UP_Z);
    assign is_digit = (c >= CH_D0) && (c <= CH_D9);
    assign is_erase = (c == erase_reg) || (c == CH_HASH) || (c == CH_BS);
    assign is_kill  = (c == kill_reg) || (c == CH_AT);
    assign is_ctrl  = (c <= CH_SP) || (c > CH_TILDE);

    assign clear_at_end = cmd.emit && cmd.final_ &&
                          ((cls_reg == CLS_NUL) || (cls_reg == CLS_EOF) ||
                           (cls_reg == CLS_DONE));

    // Edit decode, in priority order; letters win over erase and kill.
    always_comb begin
        fill_next    = fill_reg;
        lower_next   = lower_reg;
        upper_next   = upper_reg;
        digit_next   = digit_reg;
        cls_next     = CLS_QUIET;
        cr_next      = 1'b0;
        seq_len_next = SEQ_W'(1);
        dec_store    = 1'b0;
        if (cmd.accept) begin
            priority if (!in_op) begin
                fill_next  = '0;
                lower_next = 1'b0;
                upper_next = 1'b0;
                digit_next = 1'b0;
            end else if (c == CH_NUL) begin
                cls_next = CLS_NUL;
            end else if (c == eof_reg) begin
                cls_next = CLS_EOF;
            end else if ((c == CH_CR) || (c == CH_LF) ||
                         (fill_reg >= FILL_W'(LINE_CAPACITY))) begin
                cls_next     = CLS_DONE;
                cr_next      = (c == CH_CR);
                seq_len_next = SEQ_W'(fill_reg) + SEQ_W'(2);
            end else if (!is_lower && !is_upper && is_erase) begin
                if (fill_reg != '0) begin
                    cls_next     = CLS_ERASE;
                    fill_next    = fill_reg - FILL_W'(1);
                    seq_len_next = slow_reg ? SEQ_W'(1) : SEQ_W'(3);
                end
            end else if (!is_lower && !is_upper && is_kill) begin
                cls_next  = CLS_KILL;
                fill_next = '0;
                if (slow_reg) begin
                    seq_len_next = SEQ_W'(3);
                end else if (fill_reg != '0) begin
                    seq_len_next = SEQ_W'(BLANK_RUN + 3);
                end else begin
                    seq_len_next = SEQ_W'(2);
                end
            end else begin
                lower_next = lower_reg | is_lower;
                upper_next = upper_reg | is_upper;
                digit_next = digit_reg | is_digit;
                if (!(ignore_reg && is_ctrl)) begin
                    cls_next  = CLS_STORE;
                    dec_store = 1'b1;
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
        end else if (clear_at_end) begin
            fill_next  = '0;
            lower_next = 1'b0;
            upper_next = 1'b0;
            digit_next = 1'b0;
        end
    end

    // Stored bytes are prefetched one result ahead; the read at step k
    // feeds the result at step k+1.
    assign ram_we = cmd.accept && dec_store;
    assign rd_idx = step - SEQ_W'(1);
    assign ram_re = cmd.emit && (cls_reg == CLS_DONE) && (step != '0) &&
                    (rd_idx < SEQ_W'(fill_reg));

    lle_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_CAPACITY)
    ) u_line_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (c),
        .re    (ram_re),
        .raddr (rd_idx[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Result for the current step
    always_comb begin
        item_kind = KIND_ECHO;
        item_char = '0;
        unique case (cls_reg)
            CLS_QUIET, CLS_NUL, CLS_EOF: begin
                item_kind = KIND_STATUS;
            end
            CLS_STORE: begin
                item_char = raw_reg;
            end
            CLS_ERASE: begin
                if (slow_reg) begin
                    item_char = raw_reg;
                end else if (step == SEQ_W'(1)) begin
                    item_char = {1'b0, CH_SP};
                end else begin
                    item_char = {1'b0, CH_BS};
                end
            end
            CLS_KILL: begin
                if (step == '0) begin
                    item_char = raw_reg;
                end else if (step == SEQ_W'(1)) begin
                    item_char = {1'b0, CH_CR};
                end else if (slow_reg) begin
                    item_char = {1'b0, CH_LF};
                end else if (cmd.final_) begin
                    item_char = {1'b0, CH_CR};
                end else begin
                    item_char = {1'b0, CH_SP};
                end
            end
            CLS_DONE: begin
                if (step == '0) begin
                    item_char = {1'b0, CH_CR};
                end else if (step == SEQ_W'(1)) begin
                    item_char = {1'b0, CH_LF};
                end else begin
                    item_kind = KIND_LINE;
                    item_char = {1'b0, ram_rdata};
                end
            end
            default: begin
                item_kind = KIND_STATUS;
            end
        endcase
    end

    assign item_byte = (item_kind == KIND_ECHO) ? echo_parity(item_char, parity_reg)
                                                : item_char;

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            erase_reg   <= ERASE_RST;
            kill_reg    <= KILL_RST;
            eof_reg     <= EOF_RST;
            ignore_reg  <= 1'b0;
            slow_reg    <= 1'b0;
            parity_reg  <= PAR_NONE;
            fill_reg    <= '0;
            lower_reg   <= 1'b0;
            upper_reg   <= 1'b0;
            digit_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_ERASE:  erase_reg  <= cfg_data[CHAR_W-1:0];
                    CFG_KILL:   kill_reg   <= cfg_data[CHAR_W-1:0];
                    CFG_EOF:    eof_reg    <= cfg_data[CHAR_W-1:0];
                    CFG_IGNORE: ignore_reg <= cfg_data[0];
                    CFG_SLOW:   slow_reg   <= cfg_data[0];
                    CFG_PARITY: parity_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end
            fill_reg  <= fill_next;
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            digit_reg <= digit_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cls_reg     <= cls_next;
            raw_reg     <= in_byte;
            cr_reg      <= cr_next;
            seq_len_reg <= seq_len_next;
        end
        if (cmd.emit) begin
            kind_reg   <= item_kind;
            byte_reg   <= item_byte;
            status_reg <= cmd.final_ ? status_of(cls_reg) : STAT_EDIT;
            len_reg    <= LINE_LEN_W'(fill_reg);
            olower_reg <= lower_reg;
            oupper_reg <= upper_reg;
            odigit_reg <= digit_reg;
            ocr_reg    <= cr_reg;
            last_reg   <= cmd.final_;
        end
    end

    assign seq_len  = seq_len_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'b0000, ocr_reg, odigit_reg, oupper_reg, olower_reg,
                       len_reg, status_reg, byte_reg};

endmodule

// File: rtl/login_line_editor_top.sv
// Top level of the login line editor: controller, datapath and ports.
//
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   s_tdata rx_byte, s_tuser operation
//  m_       out  m_tvalid/m_tready   m_tdata result fields, m_tuser kind, m_tlast last
//  cfg_     in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// An input beat that gives N results is accepted, then sends one result per
// cycle into the output register unless stalled (N is 1 to BLANK_RUN+3, or 2 to
// LINE_CAPACITY+2 for a finished line); line bytes are read one step ahead.
// m_tready low holds the output register and pauses the sequence; the next
// beat is taken while the last result still waits. Reset is synchronous,
// active low, with no clearing pass; cfg_ready is always high.
module login_line_editor_top import lle_pkg::*; #(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
    parameter int BLANK_RUN     = BLANK_RUN_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
    input  logic                   s_tuser,   // [0] operation
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] out_byte, [10:8] status, [15:11] line_length, [16] has_lower,
    // [17] has_upper, [18] has_digit, [19] ended_by_cr, [23:20] zero
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic [KIND_W-1:0]      m_tuser,   // [1:0] kind
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SEQ_MAX = (BLANK_RUN + 3 > LINE_CAPACITY + 2) ? BLANK_RUN + 3
                                                                 : LINE_CAPACITY + 2;
    localparam int SEQ_W   = $clog2(SEQ_MAX + 1);

    dp_cmd_t          cmd;
    logic [SEQ_W-1:0] step;
    logic [SEQ_W-1:0] seq_len;
    logic             out_free;

    assign cfg_ready = 1'b1;

    lle_ctrl #(
        .SEQ_W (SEQ_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .seq_len  (seq_len),
        .cmd      (cmd),
        .step     (step)
    );

    lle_datapath #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .BLANK_RUN     (BLANK_RUN),
        .SEQ_W         (SEQ_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_tuser),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .step      (step),
        .seq_len   (seq_len),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // one beat at a time: no accept in the cycle after an accept
    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while previous beat still in work");

    // status is only reported on the final result of a beat
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[10:8] == STAT_EDIT))
        else $error("status on a non-final result");

    // stored line bytes are 7-bit
    a_line_7bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_LINE)) |-> !m_tdata[7])
        else $error("line byte with bit 7 set");

    // reported length never exceeds the line capacity
    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((LINE_CAPACITY >= 32) ||
                      (m_tdata[15:11] <= LINE_LEN_W'(LINE_CAPACITY))))
        else $error("line length beyond capacity");

endmodule
